// File: rtl/jbt_pkg.sv
// types and constants shared by the json byte tokenizer modules
`timescale 1ns / 1ps

package jbt_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int MAX_RESULTS = 3;

    // magnitude limit of a negative int, one above the positive limit
    localparam logic [VALUE_WIDTH-1:0] INT_CAP = VALUE_WIDTH'(1) << (VALUE_WIDTH - 1);
    localparam logic [VALUE_WIDTH-1:0] INT_MAX = INT_CAP - VALUE_WIDTH'(1);

    localparam logic [3:0] TOK_END    = 4'd0;
    localparam logic [3:0] TOK_LBRACK = 4'd1;
    localparam logic [3:0] TOK_RBRACK = 4'd2;
    localparam logic [3:0] TOK_LBRACE = 4'd3;
    localparam logic [3:0] TOK_RBRACE = 4'd4;
    localparam logic [3:0] TOK_COLON  = 4'd5;
    localparam logic [3:0] TOK_COMMA  = 4'd6;
    localparam logic [3:0] TOK_TRUE   = 4'd7;
    localparam logic [3:0] TOK_STRING = 4'd10;
    localparam logic [3:0] TOK_INT    = 4'd11;
    localparam logic [3:0] TOK_REAL   = 4'd12;
    localparam logic [3:0] TOK_ERROR  = 4'd13;

    localparam logic OUT_TOKEN   = 1'b0;
    localparam logic OUT_CONTENT = 1'b1;

    // keyword select, in token order from true
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_KEY,
        MODE_STR,
        MODE_ESC,
        MODE_HEX,
        MODE_NSIGN,
        MODE_NZERO,
        MODE_NINT,
        MODE_NDOT,
        MODE_NFRAC,
        MODE_NE,
        MODE_NESIGN,
        MODE_NEXP
    } lex_mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic               out_kind;
        logic [3:0]         token_kind;
        logic [7:0]         data_byte;
        logic signed [63:0] int_value;
        logic               int_overflow;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]                    count;
        result_t [MAX_RESULTS-1:0]     slot;
    } res_bundle_t;

    function automatic result_t tok_result(input logic [3:0] kind);
        result_t r;
        r = '0;
        r.out_kind   = OUT_TOKEN;
        r.token_kind = kind;
        return r;
    endfunction

    function automatic result_t byte_result(input logic [7:0] b);
        result_t r;
        r = '0;
        r.out_kind   = OUT_CONTENT;
        r.token_kind = TOK_STRING;
        r.data_byte  = b;
        return r;
    endfunction

endpackage

// File: rtl/json_byte_tokenizer_core.sv
// top level of the json byte tokenizer: input register, lexer, result register
//
//  channel   direction  handshake                  payload
//  item      in         item_valid / item_stall    item_t   (in_byte, end_of_input)
//  result    out        result_valid / result_stall result_t (one token or content byte)
//
// one byte per cycle enters while each byte yields at most one result and no
// result stalls; a byte that yields k results holds the result register until
// all k are taken. an accepted byte goes from the input register to the result register.
// reset clears the lexer to idle between tokens and empties both registers.
// a stalled result holds its register; the input register then fills and
// item_stall rises.
`timescale 1ns / 1ps

module json_byte_tokenizer_core
    import jbt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic        in_valid_reg;
    item_t       item_reg;
    logic        can_load;
    logic        advance;
    logic        accept;
    res_bundle_t bundle;

    assign advance    = in_valid_reg && can_load;
    assign item_stall = in_valid_reg && !can_load;
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
    end

    jbt_lex u_lex (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .bundle  (bundle)
    );

    jbt_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance),
        .bundle       (bundle),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: rtl/jbt_lex.sv
// lexer state and single-pass decode of one byte into up to three results
`timescale 1ns / 1ps

module jbt_lex
    import jbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  item_t       item,
    output res_bundle_t bundle
);

    localparam int PW = VALUE_WIDTH + 4;

    function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        case (sel)
            KW_FALSE:
            begin
                case (pos)
                    3'd0: ch = "f";
                    3'd1: ch = "a";
                    3'd2: ch = "l";
                    3'd3: ch = "s";
                    3'd4: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
            KW_NULL:
            begin
                case (pos)
                    3'd0: ch = "n";
                    3'd1: ch = "u";
                    3'd2: ch = "l";
                    3'd3: ch = "l";
                    default: ch = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0: ch = "t";
                    3'd1: ch = "r";
                    3'd2: ch = "u";
                    3'd3: ch = "e";
                    default: ch = 8'h00;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] kw_len(input logic [1:0] sel);
        return (sel == KW_FALSE) ? 4'd5 : 4'd4;
    endfunction

    lex_mode_t              mode_reg, mode_next;
    logic [1:0]             sel_reg, sel_next;
    logic [2:0]             pos_reg, pos_next;
    logic [2:0]             hcnt_reg, hcnt_next;
    logic [15:0]            hacc_reg, hacc_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic                   neg_reg, neg_next;
    logic                   sat_reg, sat_next;
    logic                   real_reg, real_next;

    logic [7:0]             c;
    logic                   is_end;
    logic                   digit_ok;
    logic [3:0]             dval;
    logic                   expo;
    logic                   is_sign;
    logic [PW-1:0]          prod;
    logic                   over;
    logic [VALUE_WIDTH-1:0] acc_digit;
    logic [1:0]             kw_sel;
    logic                   kw_match;
    logic                   kw_last;
    logic                   hex_ok;
    logic [3:0]             hex_dig;
    logic [15:0]            hex_new;
    logic [2:0]             hex_inc;
    logic                   hex_full;
    logic                   num_done;
    logic                   num_complete;
    logic                   idle_pass;
    logic                   idle_emit;
    logic [3:0]             idle_kind;
    result_t                fin_res;
    result_t [MAX_RESULTS-1:0] slot;
    logic [1:0]             n;

    assign c        = item.in_byte;
    assign is_end   = item.end_of_input;
    assign digit_ok = (c >= "0") && (c <= "9");
    assign dval     = 4'(c - "0");
    assign expo     = (c == "e") || (c == "E");
    assign is_sign  = (c == "+") || (c == "-");

    // accum * 10 + digit, saturating at the negative magnitude limit
    assign prod = PW'({acc_reg, 3'b000}) + PW'({acc_reg, 1'b0}) + PW'(dval);
    assign over = prod > PW'(INT_CAP);
    assign acc_digit = over ? INT_CAP : prod[VALUE_WIDTH-1:0];

    assign kw_sel   = (sel_reg == 2'd3) ? KW_TRUE : sel_reg;
    assign kw_match = ({1'b0, pos_reg} < kw_len(kw_sel)) && (c == kw_char(kw_sel, pos_reg));
    assign kw_last  = ({1'b0, pos_reg} + 4'd1) >= kw_len(kw_sel);

    always_comb
    begin
        hex_ok  = 1'b1;
        hex_dig = 4'd0;
        if (digit_ok)
            hex_dig = dval;
        else if ((c >= "a") && (c <= "f"))
            hex_dig = 4'(c - "a" + 8'd10);
        else if ((c >= "A") && (c <= "F"))
            hex_dig = 4'(c - "A" + 8'd10);
        else
            hex_ok = 1'b0;
    end

    assign hex_new  = {hacc_reg[11:0], hex_dig};
    assign hex_inc  = hcnt_reg + 3'd1;
    assign hex_full = hex_inc >= 3'd4;

    // the byte after a complete number closes it and is lexed again from idle
    always_comb
    begin
        num_done = 1'b0;
        case (mode_reg) inside
            MODE_NZERO: num_done = (c != ".") && !expo;
            MODE_NINT:  num_done = !digit_ok && (c != ".") && !expo;
            MODE_NFRAC: num_done = !digit_ok && !expo;
            MODE_NEXP:  num_done = !digit_ok;
            default:    num_done = 1'b0;
        endcase
    end

    assign num_complete = (mode_reg == MODE_NZERO) || (mode_reg == MODE_NINT) ||
                          (mode_reg == MODE_NFRAC) || (mode_reg == MODE_NEXP);
    assign idle_pass = !is_end && ((mode_reg == MODE_IDLE) || num_done);

    always_comb
    begin
        fin_res = tok_result(TOK_INT);
        if (real_reg)
            fin_res = tok_result(TOK_REAL);
        else if (neg_reg)
        begin
            fin_res.int_value    = 64'(0) - 64'(acc_reg);
            fin_res.int_overflow = sat_reg;
        end
        else if (acc_reg > INT_MAX)
        begin
            fin_res.int_value    = 64'(INT_MAX);
            fin_res.int_overflow = 1'b1;
        end
        else
        begin
            fin_res.int_value    = 64'(acc_reg);
            fin_res.int_overflow = sat_reg;
        end
    end

    always_comb
    begin
        idle_emit = 1'b1;
        idle_kind = TOK_ERROR;
        case (c) inside
            "[": idle_kind = TOK_LBRACK;
            "]": idle_kind = TOK_RBRACK;
            "{": idle_kind = TOK_LBRACE;
            "}": idle_kind = TOK_RBRACE;
            ":": idle_kind = TOK_COLON;
            ",": idle_kind = TOK_COMMA;
            // blanks and bytes that open a token
            8'h20, 8'h09, 8'h0A, 8'h0D, "t", "f", "n", "\"", "-", ["0":"9"]:
                idle_emit = 1'b0;
            default: idle_kind = TOK_ERROR;
        endcase
    end

    // next state
    always_comb
    begin
        mode_next = mode_reg;
        sel_next  = sel_reg;
        pos_next  = pos_reg;
        hcnt_next = hcnt_reg;
        hacc_next = hacc_reg;
        acc_next  = acc_reg;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        real_next = real_reg;
        if (is_end)
        begin
            mode_next = MODE_IDLE;
            sel_next  = '0;
            pos_next  = '0;
            hcnt_next = '0;
            hacc_next = '0;
            acc_next  = '0;
            neg_next  = 1'b0;
            sat_next  = 1'b0;
            real_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE: ;
                MODE_KEY:
                begin
                    pos_next = pos_reg + 3'd1;
                    if (!kw_match || kw_last)
                    begin
                        mode_next = MODE_IDLE;
                        pos_next  = '0;
                    end
                end
                MODE_STR:
                begin
                    if (c == "\"")
                        mode_next = MODE_IDLE;
                    else if (c == "\\")
                        mode_next = MODE_ESC;
                end
                MODE_ESC:
                begin
                    mode_next = MODE_STR;
                    case (c) inside
                        "b", "f", "n", "r", "t", "\\", "\"", "/": ;
                        "u":
                        begin
                            hcnt_next = '0;
                            hacc_next = '0;
                            mode_next = MODE_HEX;
                        end
                        default: mode_next = MODE_IDLE;
                    endcase
                end
                MODE_HEX:
                begin
                    if (!hex_ok || hex_full)
                    begin
                        hcnt_next = '0;
                        hacc_next = '0;
                        mode_next = hex_ok ? MODE_STR : MODE_IDLE;
                    end
                    else
                    begin
                        hcnt_next = hex_inc;
                        hacc_next = hex_new;
                    end
                end
                MODE_NSIGN:
                begin
                    if (c == "0")
                        mode_next = MODE_NZERO;
                    else if (digit_ok)
                    begin
                        acc_next  = acc_digit;
                        sat_next  = sat_reg | over;
                        mode_next = MODE_NINT;
                    end
                    else
                        mode_next = MODE_IDLE;
                end
                MODE_NZERO, MODE_NINT:
                begin
                    if ((mode_reg == MODE_NINT) && digit_ok)
                    begin
                        acc_next = acc_digit;
                        sat_next = sat_reg | over;
                    end
                    else if (c == ".")
                    begin
                        real_next = 1'b1;
                        mode_next = MODE_NDOT;
                    end
                    else if (expo)
                    begin
                        real_next = 1'b1;
                        mode_next = MODE_NE;
                    end
                    else
                        mode_next = MODE_IDLE;
                end
                MODE_NDOT:   mode_next = digit_ok ? MODE_NFRAC : MODE_IDLE;
                MODE_NFRAC:
                begin
                    if (expo)
                        mode_next = MODE_NE;
                    else if (!digit_ok)
                        mode_next = MODE_IDLE;
                end
                MODE_NE:
                begin
                    if (is_sign)
                        mode_next = MODE_NESIGN;
                    else if (digit_ok)
                        mode_next = MODE_NEXP;
                    else
                        mode_next = MODE_IDLE;
                end
                MODE_NESIGN: mode_next = digit_ok ? MODE_NEXP : MODE_IDLE;
                MODE_NEXP:   mode_next = digit_ok ? MODE_NEXP : MODE_IDLE;
                default:     mode_next = MODE_IDLE;
            endcase

            // a number that ends or fails leaves the accumulator clear
            if (mode_reg >= MODE_NSIGN && mode_next == MODE_IDLE)
            begin
                acc_next  = '0;
                neg_next  = 1'b0;
                sat_next  = 1'b0;
                real_next = 1'b0;
            end

            if (idle_pass)
            begin
                case (c) inside
                    "t", "f", "n":
                    begin
                        sel_next  = (c == "t") ? KW_TRUE : (c == "f") ? KW_FALSE : KW_NULL;
                        pos_next  = 3'd1;
                        mode_next = MODE_KEY;
                    end
                    "\"": mode_next = MODE_STR;
                    "-":
                    begin
                        acc_next  = '0;
                        neg_next  = 1'b1;
                        sat_next  = 1'b0;
                        real_next = 1'b0;
                        mode_next = MODE_NSIGN;
                    end
                    ["0":"9"]:
                    begin
                        neg_next  = 1'b0;
                        sat_next  = 1'b0;
                        real_next = 1'b0;
                        acc_next  = VALUE_WIDTH'(dval);
                        mode_next = (c == "0") ? MODE_NZERO : MODE_NINT;
                    end
                    default: ;
                endcase
            end
        end
    end

    // results
    always_comb
    begin
        n    = '0;
        slot = '0;
        if (is_end)
        begin
            if (num_complete)
            begin
                slot[n] = fin_res;
                n = n + 2'd1;
            end
            else if (mode_reg != MODE_IDLE)
            begin
                slot[n] = tok_result(TOK_ERROR);
                n = n + 2'd1;
            end
            slot[n] = tok_result(TOK_END);
            n = n + 2'd1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDLE: ;
                MODE_KEY:
                begin
                    if (!kw_match)
                    begin
                        slot[n] = tok_result(TOK_ERROR);
                        n = n + 2'd1;
                    end
                    else if (kw_last)
                    begin
                        slot[n] = tok_result(TOK_TRUE + 4'(kw_sel));
                        n = n + 2'd1;
                    end
                end
                MODE_STR:
                begin
                    if (c == "\"")
                    begin
                        slot[n] = tok_result(TOK_STRING);
                        n = n + 2'd1;
                    end
                    else if (c != "\\")
                    begin
                        slot[n] = byte_result(c);
                        n = n + 2'd1;
                    end
                end
                MODE_ESC:
                begin
                    n = 2'd1;
                    case (c) inside
                        "b": slot[0] = byte_result(8'h08);
                        "f": slot[0] = byte_result(8'h0C);
                        "n": slot[0] = byte_result(8'h0A);
                        "r": slot[0] = byte_result(8'h0D);
                        "t": slot[0] = byte_result(8'h09);
                        "\\", "\"", "/": slot[0] = byte_result(c);
                        "u": n = 2'd0;
                        default: slot[0] = tok_result(TOK_ERROR);
                    endcase
                end
                MODE_HEX:
                begin
                    if (!hex_ok)
                    begin
                        slot[0] = tok_result(TOK_ERROR);
                        n = 2'd1;
                    end
                    else if (hex_full)
                    begin
                        // code point to utf-8, surrogates passed through
                        if (hex_new < 16'h0080)
                        begin
                            slot[0] = byte_result(hex_new[7:0]);
                            n = 2'd1;
                        end
                        else if (hex_new < 16'h0800)
                        begin
                            slot[0] = byte_result({3'b110, hex_new[10:6]});
                            slot[1] = byte_result({2'b10, hex_new[5:0]});
                            n = 2'd2;
                        end
                        else
                        begin
                            slot[0] = byte_result({4'b1110, hex_new[15:12]});
                            slot[1] = byte_result({2'b10, hex_new[11:6]});
                            slot[2] = byte_result({2'b10, hex_new[5:0]});
                            n = 2'd3;
                        end
                    end
                end
                MODE_NSIGN, MODE_NDOT, MODE_NESIGN:
                begin
                    if (!digit_ok)
                    begin
                        slot[0] = tok_result(TOK_ERROR);
                        n = 2'd1;
                    end
                end
                MODE_NE:
                begin
                    if (!digit_ok && !is_sign)
                    begin
                        slot[0] = tok_result(TOK_ERROR);
                        n = 2'd1;
                    end
                end
                MODE_NZERO, MODE_NINT, MODE_NFRAC, MODE_NEXP:
                begin
                    if (num_done)
                    begin
                        slot[0] = fin_res;
                        n = 2'd1;
                    end
                end
                default: ;
            endcase
            if (idle_pass && idle_emit)
            begin
                slot[n] = tok_result(idle_kind);
                n = n + 2'd1;
            end
        end
    end

    assign bundle.count = n;
    assign bundle.slot  = slot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            sel_reg  <= '0;
            pos_reg  <= '0;
            hcnt_reg <= '0;
            hacc_reg <= '0;
            acc_reg  <= '0;
            neg_reg  <= 1'b0;
            sat_reg  <= 1'b0;
            real_reg <= 1'b0;
        end
        else if (advance)
        begin
            mode_reg <= mode_next;
            sel_reg  <= sel_next;
            pos_reg  <= pos_next;
            hcnt_reg <= hcnt_next;
            hacc_reg <= hacc_next;
            acc_reg  <= acc_next;
            neg_reg  <= neg_next;
            sat_reg  <= sat_next;
            real_reg <= real_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.end_of_input |=> mode_reg == MODE_IDLE)
        else $error("lexer not idle after end of input");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.end_of_input |-> bundle.count != 2'd0)
        else $error("end of input gave no end token");

    assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg != MODE_HEX |-> hcnt_reg == 3'd0)
        else $error("hex digit count left over outside unicode escape");

endmodule

// File: rtl/jbt_out.sv
// result register: holds one byte's results and hands them out one per transaction
`timescale 1ns / 1ps

module jbt_out
    import jbt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_bundle_t bundle,
    output logic        can_load,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    result_t [MAX_RESULTS-1:0] slot_reg;
    logic [1:0]                left_reg;
    logic                      pop;

    assign result_valid = left_reg != 2'd0;
    assign pop          = result_valid && !result_stall;
    // refill when empty or when the final result leaves this cycle
    assign can_load     = (left_reg == 2'd0) || ((left_reg == 2'd1) && !result_stall);

    always_comb
    begin
        result             = slot_reg[0];
        result.last_of_run = left_reg == 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            left_reg <= '0;
        else if (load)
            left_reg <= bundle.count;
        else if (pop)
            left_reg <= left_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            slot_reg <= bundle.slot;
        else if (pop)
        begin
            slot_reg[0] <= slot_reg[1];
            slot_reg[1] <= slot_reg[2];
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && !result.last_of_run |=> result_valid)
        else $error("results of one byte cut short");

    assert property (@(posedge clk) disable iff (!rst_n)
        pop && result.last_of_run && !load |=> !result_valid)
        else $error("result shown past the last of its run");

endmodule

// File: verif/json_byte_tokenizer_core_test.sv
// self-checking testbench for the json byte tokenizer core
`timescale 1ns / 1ps

module json_byte_tokenizer_core_test;
    import jbt_pkg::*;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } script_row_t;

    logic    clk;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // lexer state mirrored by the predictor
    lex_mode_t   lx_mode;
    logic [1:0]  lx_kw;
    logic [2:0]  lx_kw_pos;
    logic [2:0]  lx_hex_cnt;
    logic [15:0] lx_hex;
    logic [63:0] lx_num;
    logic        lx_neg;
    logic        lx_sat;
    logic        lx_real;

    string       kw_word [3] = '{"true", "false", "null"};
    result_t     lexed_now [$];
    result_t     tokens_due [$];
    script_row_t script [$];
    item_t       chunk [$];
    result_t     head;

    int mismatches = 0;
    int bytes_taken = 0;
    int burst_left = 0;

    json_byte_tokenizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic void put_token(input logic [3:0] kind);
        result_t r;
        r = '0;
        r.out_kind   = OUT_TOKEN;
        r.token_kind = kind;
        lexed_now.push_back(r);
    endfunction

    function automatic void put_char(input logic [7:0] b);
        result_t r;
        r = '0;
        r.out_kind   = OUT_CONTENT;
        r.token_kind = TOK_STRING;
        r.data_byte  = b;
        lexed_now.push_back(r);
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void clear_number();
        lx_num  = '0;
        lx_neg  = 1'b0;
        lx_sat  = 1'b0;
        lx_real = 1'b0;
    endfunction

    function automatic void reset_lexer();
        lx_mode    = MODE_IDLE;
        lx_kw      = '0;
        lx_kw_pos  = '0;
        lx_hex_cnt = '0;
        lx_hex     = '0;
        clear_number();
    endfunction

    // magnitude sticks at the negative limit once it would pass it
    function automatic void add_digit(input logic [7:0] c);
        logic [63:0] d;
        d = {56'd0, c - 8'h30};
        if (lx_num > (INT_CAP - d) / 64'd10)
        begin
            lx_num = INT_CAP;
            lx_sat = 1'b1;
        end
        else
            lx_num = lx_num * 64'd10 + d;
    endfunction

    function automatic void close_number();
        result_t r;
        r = '0;
        r.out_kind   = OUT_TOKEN;
        r.token_kind = TOK_INT;
        if (lx_real)
            r.token_kind = TOK_REAL;
        else if (lx_neg)
        begin
            r.int_value    = 64'd0 - lx_num;
            r.int_overflow = lx_sat;
        end
        else if (lx_num > INT_MAX)
        begin
            r.int_value    = INT_MAX;
            r.int_overflow = 1'b1;
        end
        else
        begin
            r.int_value    = lx_num;
            r.int_overflow = lx_sat;
        end
        lexed_now.push_back(r);
        clear_number();
        lx_mode = MODE_IDLE;
    endfunction

    function automatic void number_error();
        clear_number();
        lx_mode = MODE_IDLE;
        put_token(TOK_ERROR);
    endfunction

    function automatic void idle_char(input logic [7:0] c);
        case (c)
            " ", 8'h09, 8'h0A, 8'h0D: ;
            "[": put_token(TOK_LBRACK);
            "]": put_token(TOK_RBRACK);
            "{": put_token(TOK_LBRACE);
            "}": put_token(TOK_RBRACE);
            ":": put_token(TOK_COLON);
            ",": put_token(TOK_COMMA);
            "t", "f", "n":
            begin
                lx_kw     = (c == "t") ? KW_TRUE : (c == "f") ? KW_FALSE : KW_NULL;
                lx_kw_pos = 3'd1;
                lx_mode   = MODE_KEY;
            end
            "\"": lx_mode = MODE_STR;
            "-":
            begin
                clear_number();
                lx_neg  = 1'b1;
                lx_mode = MODE_NSIGN;
            end
            default:
            begin
                if (is_digit(c))
                begin
                    clear_number();
                    if (c == "0")
                        lx_mode = MODE_NZERO;
                    else
                    begin
                        add_digit(c);
                        lx_mode = MODE_NINT;
                    end
                end
                else
                    put_token(TOK_ERROR);
            end
        endcase
    endfunction

    // returns 1 when the byte closed a number and goes through idle again
    function automatic bit number_char(input logic [7:0] c);
        bit expo;
        expo = (c == "e" || c == "E");
        case (lx_mode)
            MODE_NSIGN:
            begin
                if (c == "0")
                    lx_mode = MODE_NZERO;
                else if (is_digit(c))
                begin
                    add_digit(c);
                    lx_mode = MODE_NINT;
                end
                else
                    number_error();
                return 1'b0;
            end
            MODE_NZERO, MODE_NINT:
            begin
                if (lx_mode == MODE_NINT && is_digit(c))
                begin
                    add_digit(c);
                    return 1'b0;
                end
                if (c == "." || expo)
                begin
                    lx_real = 1'b1;
                    lx_mode = (c == ".") ? MODE_NDOT : MODE_NE;
                    return 1'b0;
                end
                close_number();
                return 1'b1;
            end
            MODE_NDOT:
            begin
                if (is_digit(c))
                    lx_mode = MODE_NFRAC;
                else
                    number_error();
                return 1'b0;
            end
            MODE_NFRAC:
            begin
                if (is_digit(c))
                    return 1'b0;
                if (expo)
                begin
                    lx_mode = MODE_NE;
                    return 1'b0;
                end
                close_number();
                return 1'b1;
            end
            MODE_NE:
            begin
                if (c == "+" || c == "-")
                    lx_mode = MODE_NESIGN;
                else if (is_digit(c))
                    lx_mode = MODE_NEXP;
                else
                    number_error();
                return 1'b0;
            end
            MODE_NESIGN:
            begin
                if (is_digit(c))
                    lx_mode = MODE_NEXP;
                else
                    number_error();
                return 1'b0;
            end
            default:
            begin
                if (is_digit(c))
                    return 1'b0;
                close_number();
                return 1'b1;
            end
        endcase
    endfunction

    // results of one input transaction, left in lexed_now
    function automatic void lex_byte(input item_t it);
        logic [7:0] c;
        logic [1:0] s;
        logic [2:0] p;
        int         h;
        c = it.in_byte;
        lexed_now.delete();
        if (it.end_of_input)
        begin
            if (lx_mode == MODE_NZERO || lx_mode == MODE_NINT ||
                lx_mode == MODE_NFRAC || lx_mode == MODE_NEXP)
                close_number();
            else if (lx_mode != MODE_IDLE)
                put_token(TOK_ERROR);
            reset_lexer();
            put_token(TOK_END);
        end
        else
        begin
            case (lx_mode)
                MODE_IDLE: idle_char(c);
                MODE_KEY:
                begin
                    s = (lx_kw < 2'd3) ? lx_kw : KW_TRUE;
                    p = lx_kw_pos;
                    if (p < kw_word[s].len() && c == kw_word[s][p])
                    begin
                        p = p + 3'd1;
                        if (p >= kw_word[s].len())
                        begin
                            put_token(TOK_TRUE + {2'b00, s});
                            lx_mode = MODE_IDLE;
                            p = 3'd0;
                        end
                        lx_kw_pos = p;
                    end
                    else
                    begin
                        put_token(TOK_ERROR);
                        lx_mode   = MODE_IDLE;
                        lx_kw_pos = 3'd0;
                    end
                end
                MODE_STR:
                begin
                    if (c == "\"")
                    begin
                        put_token(TOK_STRING);
                        lx_mode = MODE_IDLE;
                    end
                    else if (c == "\\")
                        lx_mode = MODE_ESC;
                    else
                        put_char(c);
                end
                MODE_ESC:
                begin
                    lx_mode = MODE_STR;
                    case (c)
                        "b": put_char(8'h08);
                        "f": put_char(8'h0C);
                        "n": put_char(8'h0A);
                        "r": put_char(8'h0D);
                        "t": put_char(8'h09);
                        "\\", "\"", "/": put_char(c);
                        "u":
                        begin
                            lx_hex_cnt = '0;
                            lx_hex     = '0;
                            lx_mode    = MODE_HEX;
                        end
                        default:
                        begin
                            put_token(TOK_ERROR);
                            lx_mode = MODE_IDLE;
                        end
                    endcase
                end
                MODE_HEX:
                begin
                    h = -1;
                    if (is_digit(c))
                        h = c - 8'h30;
                    else if (c >= "a" && c <= "f")
                        h = c - 8'h61 + 10;
                    else if (c >= "A" && c <= "F")
                        h = c - 8'h41 + 10;
                    if (h < 0)
                    begin
                        put_token(TOK_ERROR);
                        lx_mode    = MODE_IDLE;
                        lx_hex_cnt = '0;
                        lx_hex     = '0;
                    end
                    else
                    begin
                        lx_hex     = {lx_hex[11:0], h[3:0]};
                        lx_hex_cnt = lx_hex_cnt + 3'd1;
                        if (lx_hex_cnt >= 3'd4)
                        begin
                            // code point out as utf-8, surrogates unpaired
                            if (lx_hex < 16'h0080)
                                put_char(lx_hex[7:0]);
                            else if (lx_hex < 16'h0800)
                            begin
                                put_char({3'b110, lx_hex[10:6]});
                                put_char({2'b10, lx_hex[5:0]});
                            end
                            else
                            begin
                                put_char({4'b1110, lx_hex[15:12]});
                                put_char({2'b10, lx_hex[11:6]});
                                put_char({2'b10, lx_hex[5:0]});
                            end
                            lx_hex_cnt = '0;
                            lx_hex     = '0;
                            lx_mode    = MODE_STR;
                        end
                    end
                end
                default:
                begin
                    if (number_char(c))
                        idle_char(c);
                end
            endcase
        end
        if (lexed_now.size() > 0)
            lexed_now[lexed_now.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void add_row(input logic [7:0] ch, input logic eoi, input logic typed,
                                    input logic ok, input logic [3:0] kind,
                                    input logic [7:0] data);
        script_row_t row;
        row = '0;
        row.it.in_byte      = ch;
        row.it.end_of_input = eoi;
        row.typed           = typed;
        if (typed)
        begin
            row.want.out_kind    = ok;
            row.want.token_kind  = kind;
            row.want.data_byte   = data;
            row.want.last_of_run = 1'b1;
        end
        script.push_back(row);
    endfunction

    function automatic void push_char(input logic [7:0] c);
        item_t t;
        t.in_byte      = c;
        t.end_of_input = 1'b0;
        chunk.push_back(t);
    endfunction

    // one random lexeme, mostly well formed, sometimes broken or noise
    function automatic void build_chunk();
        int          pick;
        int          n;
        int          k;
        string       text;
        logic [15:0] code;
        logic [7:0]  b;
        item_t       t;
        chunk.delete();
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 3))
                    0: push_char(" ");
                    1: push_char(8'h09);
                    2: push_char(8'h0A);
                    default: push_char(8'h0D);
                endcase
            end
        end
        else if (pick < 30)
        begin
            text = "[]{}:,";
            push_char(text[$urandom_range(0, 5)]);
        end
        else if (pick < 42)
        begin
            k = $urandom_range(0, 2);
            n = kw_word[k].len();
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n - 1);
            for (int i = 0; i < n; i++)
                push_char(kw_word[k][i]);
            if (n < kw_word[k].len())
            begin
                b = 8'($urandom_range(0, 255));
                push_char(b);
            end
        end
        else if (pick < 65)
        begin
            push_char("\"");
            repeat ($urandom_range(0, 6))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 45)
                begin
                    b = 8'($urandom_range(0, 255));
                    if (b == "\"" || b == "\\")
                        b = "a";
                    push_char(b);
                end
                else if (pick < 70)
                begin
                    text = "bfnrt\\\"/";
                    push_char("\\");
                    push_char(text[$urandom_range(0, 7)]);
                end
                else if (pick < 94)
                begin
                    case ($urandom_range(0, 3))
                        0: code = 16'($urandom_range(16'h0000, 16'h007F));
                        1: code = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
                        default: code = 16'($urandom_range(16'hD800, 16'hDFFF));
                    endcase
                    push_char("\\");
                    push_char("u");
                    for (int i = 3; i >= 0; i--)
                    begin
                        b = {4'd0, code[4*i +: 4]};
                        if (b < 8'd10)
                            b = b + 8'h30;
                        else
                            b = b - 8'd10 + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
                        push_char(b);
                    end
                end
                else if (pick < 97)
                begin
                    text = "aqxzU0";
                    push_char("\\");
                    push_char(text[$urandom_range(0, 5)]);
                end
                else
                begin
                    push_char("\\");
                    push_char("u");
                    push_char("1");
                    push_char("g");
                end
            end
            if ($urandom_range(0, 9) != 0)
                push_char("\"");
        end
        else if (pick < 88)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: text = "-";
                    1: text = "1.";
                    2: text = "7e";
                    3: text = "3E+";
                    default: text = "0.5e-";
                endcase
                text = {text, "x"};
            end
            else
            begin
                text = "";
                if ($urandom_range(0, 2) == 0)
                    text = "-";
                case ($urandom_range(0, 9))
                    0: text = {text, "9223372036854775807"};
                    1: text = {text, "9223372036854775808"};
                    2: text = {text, "99999999999999999999999"};
                    3, 4: text = {text, "0"};
                    default:
                    begin
                        b = 8'($urandom_range(8'h31, 8'h39));
                        text = {text, string'(b)};
                        repeat ($urandom_range(0, 4))
                        begin
                            b = 8'($urandom_range(8'h30, 8'h39));
                            text = {text, string'(b)};
                        end
                    end
                endcase
                if ($urandom_range(0, 4) == 0)
                begin
                    text = {text, "."};
                    repeat ($urandom_range(1, 3))
                    begin
                        b = 8'($urandom_range(8'h30, 8'h39));
                        text = {text, string'(b)};
                    end
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    if ($urandom_range(0, 1) != 0)
                        text = {text, "e"};
                    else
                        text = {text, "E"};
                    case ($urandom_range(0, 2))
                        0: text = {text, "+"};
                        1: text = {text, "-"};
                        default: ;
                    endcase
                    repeat ($urandom_range(1, 2))
                    begin
                        b = 8'($urandom_range(8'h30, 8'h39));
                        text = {text, string'(b)};
                    end
                end
            end
            for (int i = 0; i < text.len(); i++)
                push_char(text[i]);
        end
        else if (pick < 95)
        begin
            b = 8'($urandom_range(0, 255));
            push_char(b);
        end
        else
        begin
            t.in_byte      = 8'($urandom_range(0, 255));
            t.end_of_input = 1'b1;
            chunk.push_back(t);
        end
    endfunction

    // offer one input transaction in bursts; predict once it is taken
    task automatic offer(input item_t it, input logic typed, input result_t given);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        else
            burst_left--;
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        lex_byte(it);
        if (typed)
            tokens_due.push_back(given);
        else
            foreach (lexed_now[i])
                tokens_due.push_back(lexed_now[i]);
        bytes_taken++;
    endtask

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s) at %0t: ",
                      "expected kind=%0d tok=%0d data=%02h val=%0d ovf=%0d last=%0d, ",
                      "got kind=%0d tok=%0d data=%02h val=%0d ovf=%0d last=%0d"},
                     what, $realtime,
                     want.out_kind, want.token_kind, want.data_byte, want.int_value,
                     want.int_overflow, want.last_of_run,
                     got.out_kind, got.token_kind, got.data_byte, got.int_value,
                     got.int_overflow, got.last_of_run);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (tokens_due.size() == 0)
                log_mismatch("unexpected", '0, result);
            else
            begin
                head = tokens_due.pop_front();
                if (result !== head)
                    log_mismatch("value", head, result);
            end
        end
    end

    // receiver stall pattern, with one long hold-off to back up the input side
    initial
    begin : receiver
        int seg_mode;
        int seg_len;
        int hold_left;
        int phase;
        bit hold_done;
        bit stall_now;
        hold_left = 0;
        phase     = 0;
        hold_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            seg_mode = $urandom_range(0, 3);
            seg_len  = $urandom_range(8, 60);
            repeat (seg_len)
            begin
                if (!hold_done && bytes_taken >= 60)
                begin
                    hold_left = 90;
                    hold_done = 1'b1;
                end
                if (hold_left > 0)
                begin
                    stall_now = 1'b1;
                    hold_left--;
                end
                else
                begin
                    case (seg_mode)
                        0: stall_now = 1'b0;
                        1: stall_now = ($urandom_range(0, 3) == 0);
                        2: stall_now = ($urandom_range(0, 9) < 7);
                        default: stall_now = ((phase % 5) < 2);
                    endcase
                end
                phase++;
                result_stall <= stall_now;
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int    random_bytes;
        item_t closing;
        reset_lexer();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        add_row(8'h00, 1'b0, 1'b1, OUT_TOKEN,   TOK_ERROR,  8'h00); // stray byte after reset
        add_row(8'hFF, 1'b1, 1'b1, OUT_TOKEN,   TOK_END,    8'h00); // byte ignored with end
        add_row("[",   1'b0, 1'b1, OUT_TOKEN,   TOK_LBRACK, 8'h00);
        add_row("t",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("r",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("X",   1'b0, 1'b1, OUT_TOKEN,   TOK_ERROR,  8'h00); // keyword mismatch
        add_row("\"",  1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row(8'hFF, 1'b0, 1'b1, OUT_CONTENT, TOK_STRING, 8'hFF);
        add_row("\\",  1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("u",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("f",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("F",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("f",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("F",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00); // three utf-8 bytes
        add_row("\\",  1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("q",   1'b0, 1'b1, OUT_TOKEN,   TOK_ERROR,  8'h00); // bad escape
        add_row("-",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("x",   1'b0, 1'b1, OUT_TOKEN,   TOK_ERROR,  8'h00); // sign with no digit
        add_row("7",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("}",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00); // int then brace
        add_row("0",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("E",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row("1",   1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row(8'h00, 1'b1, 1'b0, OUT_TOKEN,   TOK_END,    8'h00); // end closes a real
        add_row("\"",  1'b0, 1'b0, OUT_TOKEN,   TOK_END,    8'h00);
        add_row(8'h00, 1'b1, 1'b0, OUT_TOKEN,   TOK_END,    8'h00); // end inside a string

        foreach (script[i])
            offer(script[i].it, script[i].typed, script[i].want);

        // let every directed result drain before the random part
        item_valid <= 1'b0;
        do @(posedge clk); while (tokens_due.size() != 0);

        random_bytes = 0;
        while (random_bytes < 140)
        begin
            build_chunk();
            foreach (chunk[i])
            begin
                offer(chunk[i], 1'b0, '0);
                random_bytes++;
            end
        end
        closing.in_byte      = 8'($urandom_range(0, 255));
        closing.end_of_input = 1'b1;
        offer(closing, 1'b0, '0);

        item_valid <= 1'b0;
        do @(posedge clk); while (tokens_due.size() != 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
